>>> design/stepper_prescaler_period_select_assert.svh
// Assertion macros shared by the prescaler/period select RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef STEPPER_PRESCALER_PERIOD_SELECT_ASSERT_SVH
`define STEPPER_PRESCALER_PERIOD_SELECT_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define SPPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define SPPS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/spps_pkg.sv
// Constants, register codes and helper functions for the prescaler/period select block.
// No dependencies; imported by spps_div and stepper_prescaler_period_select.
package spps_pkg;

    localparam int DIV_NW    = 38;      // dividend and quotient width
    localparam int DIV_DW    = 24;      // divisor width
    localparam int DIV_LAT   = DIV_NW;  // one quotient bit per stage
    localparam int NUM_PRESC = 4;
    localparam int CLK_W     = 25;
    localparam int SPR_W     = 13;
    localparam int ACC_W     = 7;
    localparam int RPM_W     = 11;
    localparam int PER_W     = 8;
    localparam int IDX_W     = 2;
    localparam int O16_W     = 16;
    localparam int CLK60_W   = 31;
    localparam int POT_W     = 8;

    localparam logic [CLK_W-1:0] CORE_CLK_RST  = 25'd20000000;
    localparam logic [SPR_W-1:0] STEPS_RST     = 13'd1600;
    localparam logic [ACC_W-1:0] RAMP_RST      = 7'd10;
    localparam logic [PER_W-1:0] PERIOD_MAX    = 8'd255;
    localparam logic [O16_W-1:0] SAT16         = 16'hFFFF;
    localparam logic [IDX_W-1:0] IDX_SLOWEST   = 2'd3;
    localparam logic [RPM_W-1:0] MAX_RPM       = 11'd1200;

    typedef enum logic [1:0] {
        REG_CORE_CLK = 2'd0,
        REG_STEPS    = 2'd1,
        REG_RAMP     = 2'd2
    } t_reg_idx;

    // Potentiometer sample to target rpm; x/6 done as (x*171)>>10, exact for x < 256.
    function automatic logic [RPM_W-1:0] pot_to_rpm(input logic [POT_W-1:0] pot);
        logic [POT_W-1:0] inv;
        logic [17:0]      prod;
        logic [5:0]       v;
        logic [RPM_W-1:0] r;
        inv  = 8'd255 - pot;
        prod = {10'd0, inv} * 18'd171;
        v    = prod[15:10] + 6'd1;
        if (v < 6'd11) begin
            r = MAX_RPM - RPM_W'(v) * 11'd100;
        end else begin
            r = 11'd136 - RPM_W'(v) * 11'd3;
        end
        return r;
    endfunction

    // Prescaler 16 << (2*idx) as a shift amount.
    function automatic logic [3:0] presc_shift(input logic [IDX_W-1:0] idx);
        return 4'd4 + {1'b0, idx, 1'b0};
    endfunction

endpackage

>>> design/spps_div.sv
// Pipelined restoring divider, one quotient bit per stage, fixed widths.
// Depends on spps_pkg (DIV_NW, DIV_DW, DIV_LAT).
module spps_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [spps_pkg::DIV_NW-1:0] i_num,
    input  logic [spps_pkg::DIV_DW-1:0] i_den,
    output logic [spps_pkg::DIV_NW-1:0] o_quo
);
    import spps_pkg::*;

    logic [DIV_DW-1:0] r_rem [1:DIV_LAT-1];
    logic [DIV_NW-1:0] r_acc [1:DIV_LAT];
    logic [DIV_DW-1:0] r_den [1:DIV_LAT-1];

    logic [DIV_DW-1:0] w_rem_in [0:DIV_LAT-1];
    logic [DIV_NW-1:0] w_acc_in [0:DIV_LAT-1];
    logic [DIV_DW-1:0] w_den_in [0:DIV_LAT-1];

    assign w_rem_in[0] = '0;
    assign w_acc_in[0] = i_num;
    assign w_den_in[0] = i_den;

    genvar k;
    for (k = 1; k < DIV_LAT; k++) begin : g_link
        assign w_rem_in[k] = r_rem[k];
        assign w_acc_in[k] = r_acc[k];
        assign w_den_in[k] = r_den[k];
    end

    for (k = 0; k < DIV_LAT; k++) begin : g_stage
        logic [DIV_DW:0] w_try;
        logic [DIV_DW:0] w_sub;
        logic            w_ge;
        // shift in the next dividend bit, subtract when it fits
        assign w_try = {w_rem_in[k], w_acc_in[k][DIV_NW-1]};
        assign w_sub = w_try - {1'b0, w_den_in[k]};
        assign w_ge  = w_try >= {1'b0, w_den_in[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k+1] <= {w_acc_in[k][DIV_NW-2:0], w_ge};
            end
        end
        if (k < DIV_LAT - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? w_sub[DIV_DW-1:0] : w_try[DIV_DW-1:0];
                    r_den[k+1] <= w_den_in[k];
                end
            end
        end
    end

    assign o_quo = r_acc[DIV_LAT];

endmodule

>>> design/stepper_prescaler_period_select.sv
// Stepper prescaler and period select: pot sample in, timer setting out.
// Depends on spps_pkg, spps_div and stepper_prescaler_period_select_assert.svh.
//
//  channel | group       | direction | payload
//  --------+-------------+-----------+----------------------------------------------
//  input   | s_axis_*    | in        | tdata[7:0] pot_sample
//  result  | m_axis_*    | out       | target_rpm, prescaler_index, period, rpm, ramp
//  config  | i_cfg_*     | in        | index 0 clock hz, 1 steps/rev, 2 ramp accel
//
// One sample transfer per cycle while the result port is not stalled. Three ranks of
// 38-stage restoring dividers run in series (period, achieved rpm with one divider per
// prescaler, ramp ticks), each retiring one quotient bit per stage.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// A stall at the result port holds every stage; nothing is dropped or repeated.
module stepper_prescaler_period_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pot_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [10:0] target_rpm, [12:11] prescaler_index, [20:13] period_count,
    // [36:21] achieved_rpm, [52:37] ramp_ticks, [55:53] zero
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [spps_pkg::CLK_W-1:0] i_cfg_data
);
    import spps_pkg::*;

    typedef struct packed {
        logic [RPM_W-1:0]                      rpm;
        logic [NUM_PRESC-1:0]                  ok;
        logic [NUM_PRESC-1:0][PER_W-1:0]       per;
    } t_side_b;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic [IDX_W-1:0] idx;
        logic [PER_W-1:0] per;
        logic [O16_W-1:0] ach;
    } t_side_c;

    // configuration and derived numerators
    logic [CLK_W-1:0]   r_core;
    logic [SPR_W-1:0]   r_spr;
    logic [ACC_W-1:0]   r_ra;
    logic [CLK60_W-1:0] r_clk60;
    logic [DIV_NW-1:0]  r_rnum;

    // global advance: the whole pipe moves when the result slot can take data
    logic w_adv;

    logic               r0_v, r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r_out_valid;
    logic [DIV_LAT-1:0] r_va, r_vb, r_vc;

    logic [RPM_W-1:0]   r0_rpm, r1_rpm;
    logic [DIV_DW-1:0]  r1_den;
    logic [RPM_W-1:0]   r_a_rpm [0:DIV_LAT-1];
    logic [DIV_NW-1:0]  w_quo_a;

    logic [NUM_PRESC-1:0]            r2_ok;
    logic [PER_W-1:0]                r2_per [NUM_PRESC];
    logic [RPM_W-1:0]                r2_rpm;
    logic [NUM_PRESC-1:0]            w_ok;
    logic [PER_W-1:0]                w_per [NUM_PRESC];

    logic [DIV_DW-1:0]  r3_den [NUM_PRESC];
    logic [DIV_NW-1:0]  r3_num [NUM_PRESC];
    t_side_b            r3_side;
    t_side_b            r_b_side [0:DIV_LAT-1];
    logic [DIV_NW-1:0]  w_quo_b [NUM_PRESC];

    logic [DIV_NW-1:0]  r4_diff [NUM_PRESC];
    logic [O16_W-1:0]   r4_ach  [NUM_PRESC];
    t_side_b            r4_side;

    logic [1:0]         r5_ok;
    logic [IDX_W-1:0]   r5_idx  [2];
    logic [DIV_NW-1:0]  r5_diff [2];
    logic [O16_W-1:0]   r5_ach  [2];
    logic [PER_W-1:0]   r5_per  [2];
    logic [RPM_W-1:0]   r5_rpm;

    logic               r6_ok;
    t_side_c            r6_side;
    logic [DIV_DW-1:0]  r7_den;
    logic [DIV_NW-1:0]  r7_num;
    t_side_c            r7_side;
    t_side_c            r_c_side [0:DIV_LAT-1];
    logic [DIV_NW-1:0]  w_quo_c;

    logic [RPM_W-1:0]   r_out_rpm;
    logic [IDX_W-1:0]   r_out_idx;
    logic [PER_W-1:0]   r_out_per;
    logic [O16_W-1:0]   r_out_ach;
    logic [O16_W-1:0]   r_out_ramp;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_ramp, r_out_ach, r_out_per, r_out_idx, r_out_rpm};

    // register writes; an index past the list is accepted and dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= CORE_CLK_RST;
            r_spr  <= STEPS_RST;
            r_ra   <= RAMP_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CORE_CLK: r_core <= i_cfg_data;
                REG_STEPS:    r_spr  <= i_cfg_data[SPR_W-1:0];
                REG_RAMP:     r_ra   <= i_cfg_data[ACC_W-1:0];
                default:      ;
            endcase
        end
    end

    // clock*60 is registered from the clock register; ramp_accel*clock*60 is registered from it
    always_ff @(posedge i_clk) begin
        r_clk60 <= {6'd0, r_core} * 31'd60;
        r_rnum  <= {31'd0, r_ra} * {7'd0, r_clk60};
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v        <= 1'b0;
            r1_v        <= 1'b0;
            r_va        <= '0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r_vb        <= '0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r6_v        <= 1'b0;
            r7_v        <= 1'b0;
            r_vc        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r0_v        <= s_axis_tvalid;
            r1_v        <= r0_v;
            r_va        <= {r_va[DIV_LAT-2:0], r1_v};
            r2_v        <= r_va[DIV_LAT-1];
            r3_v        <= r2_v;
            r_vb        <= {r_vb[DIV_LAT-2:0], r3_v};
            r4_v        <= r_vb[DIV_LAT-1];
            r5_v        <= r4_v;
            r6_v        <= r5_v;
            r7_v        <= r6_v;
            r_vc        <= {r_vc[DIV_LAT-2:0], r7_v};
            r_out_valid <= r_vc[DIV_LAT-1];
        end
    end

    // period candidates: Q = clk60/(rpm*spr), period = Q >> prescaler shift
    always_comb begin
        logic [DIV_NW-1:0] sh;
        for (int n = 0; n < NUM_PRESC; n++) begin
            sh    = w_quo_a >> presc_shift(IDX_W'(n));
            w_ok[n] = (r_spr != '0) && (sh[DIV_NW-1:PER_W] == '0) && (sh[PER_W-1:0] != '0);
            w_per[n] = sh[PER_W-1:0];
        end
        // slowest prescaler falls back to the safe period when its own is unusable
        if (!w_ok[NUM_PRESC-1]) begin
            w_per[NUM_PRESC-1] = PERIOD_MAX;
        end
    end

    spps_div u_div_per (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({7'd0, r_clk60}),
        .i_den (r1_den),
        .o_quo (w_quo_a)
    );

    for (genvar g = 0; g < NUM_PRESC; g++) begin : g_ach
        spps_div u_div_ach (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r3_num[g]),
            .i_den (r3_den[g]),
            .o_quo (w_quo_b[g])
        );
    end

    spps_div u_div_ramp (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r7_num),
        .i_den (r7_den),
        .o_quo (w_quo_c)
    );

    always_ff @(posedge i_clk) begin
        logic [DIV_NW-1:0] ach;
        logic [DIV_NW-1:0] rpm_x;
        logic              take_b;
        if (w_adv) begin
            // rpm lookup, then the period divisor
            r0_rpm <= pot_to_rpm(s_axis_tdata);
            r1_rpm <= r0_rpm;
            r1_den <= DIV_DW'(r0_rpm) * DIV_DW'(r_spr);

            r_a_rpm[0] <= r1_rpm;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_a_rpm[k] <= r_a_rpm[k-1];
            end

            // hold candidates
            r2_rpm <= r_a_rpm[DIV_LAT-1];
            r2_ok  <= w_ok;
            for (int n = 0; n < NUM_PRESC; n++) begin
                r2_per[n] <= w_per[n];
            end

            // achieved rpm divisors and numerators per prescaler
            r3_side.rpm <= r2_rpm;
            r3_side.ok  <= r2_ok;
            for (int n = 0; n < NUM_PRESC; n++) begin
                r3_side.per[n] <= r2_per[n];
                r3_den[n] <= DIV_DW'(r2_per[n]) * DIV_DW'(r_spr);
                r3_num[n] <= {7'd0, r_clk60} >> presc_shift(IDX_W'(n));
            end

            r_b_side[0] <= r3_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_b_side[k] <= r_b_side[k-1];
            end

            // distance to target and saturated achieved rpm
            r4_side <= r_b_side[DIV_LAT-1];
            rpm_x = {27'd0, r_b_side[DIV_LAT-1].rpm};
            for (int n = 0; n < NUM_PRESC; n++) begin
                ach = w_quo_b[n];
                r4_diff[n] <= (ach > rpm_x) ? ach - rpm_x : rpm_x - ach;
                if (r_spr == '0 || ach[DIV_NW-1:O16_W] != '0) begin
                    r4_ach[n] <= SAT16;
                end else begin
                    r4_ach[n] <= ach[O16_W-1:0];
                end
            end

            // pairwise pick: lower index wins a tie; with no usable one take the upper
            r5_rpm <= r4_side.rpm;
            for (int p = 0; p < 2; p++) begin
                if (r4_side.ok[2*p+1]) begin
                    take_b = !r4_side.ok[2*p] || (r4_diff[2*p+1] < r4_diff[2*p]);
                end else begin
                    take_b = !r4_side.ok[2*p];
                end
                r5_ok[p]   <= r4_side.ok[2*p] || r4_side.ok[2*p+1];
                r5_idx[p]  <= take_b ? IDX_W'(2*p+1) : IDX_W'(2*p);
                r5_diff[p] <= take_b ? r4_diff[2*p+1] : r4_diff[2*p];
                r5_ach[p]  <= take_b ? r4_ach[2*p+1] : r4_ach[2*p];
                r5_per[p]  <= take_b ? r4_side.per[2*p+1] : r4_side.per[2*p];
            end

            // final pick, same rule
            if (r5_ok[1]) begin
                take_b = !r5_ok[0] || (r5_diff[1] < r5_diff[0]);
            end else begin
                take_b = !r5_ok[0];
            end
            r6_ok       <= r5_ok[0] || r5_ok[1];
            r6_side.rpm <= r5_rpm;
            r6_side.idx <= take_b ? r5_idx[1] : r5_idx[0];
            r6_side.per <= take_b ? r5_per[1] : r5_per[0];
            r6_side.ach <= take_b ? r5_ach[1] : r5_ach[0];

            // ramp divisor prescaler*period*1200, prescaler folded into the numerator
            r7_side <= r6_side;
            r7_den  <= DIV_DW'(r6_side.per) * DIV_DW'(MAX_RPM);
            r7_num  <= r_rnum >> presc_shift(r6_side.idx);

            r_c_side[0] <= r7_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_c_side[k] <= r_c_side[k-1];
            end

            r_out_rpm <= r_c_side[DIV_LAT-1].rpm;
            r_out_idx <= r_c_side[DIV_LAT-1].idx;
            r_out_per <= r_c_side[DIV_LAT-1].per;
            r_out_ach <= r_c_side[DIV_LAT-1].ach;
            if (w_quo_c[DIV_NW-1:O16_W] != '0) begin
                r_out_ramp <= SAT16;
            end else begin
                r_out_ramp <= w_quo_c[O16_W-1:0];
            end
        end
    end

    `include "stepper_prescaler_period_select_assert.svh"

    `SPPS_ASSERT(a_out_period_nonzero, i_clk, i_rst_n, r_out_valid |-> (r_out_per != '0), "zero period on result")
    `SPPS_ASSERT(a_out_rpm_range, i_clk, i_rst_n, r_out_valid |-> (r_out_rpm <= MAX_RPM && r_out_rpm >= 11'd7), "target rpm out of range")
    `SPPS_ASSERT(a_slowest_fallback, i_clk, i_rst_n, (r2_v && !r2_ok[NUM_PRESC-1]) |-> (r2_per[NUM_PRESC-1] == PERIOD_MAX), "fallback period missing")
    `SPPS_NEVER(a_none_not_slowest, i_clk, i_rst_n, r6_v && !r6_ok && (r6_side.idx != IDX_SLOWEST), "no candidate but not slowest prescaler")

endmodule
